// ===== rtl/core/bcc_pkg.sv =====
package bcc_pkg;

  localparam int CFG_W = 10;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_INCREMENT = 2'd0,
    CFG_TICK_PERIOD    = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_SET  = 2'd1,
    MODE_GET  = 2'd2
  } mode_t;

  localparam logic [CFG_W-1:0] TICK_INCREMENT_RESET = 10'd10;
  localparam logic [CFG_W-1:0] TICK_PERIOD_RESET    = 10'd564;

  localparam logic [11:0] YEAR_RESET = 12'd1980;
  localparam logic [11:0] YEAR_BASE  = 12'd1900;
  localparam logic [11:0] YEAR_PIVOT = 12'd1980;
  localparam logic [11:0] CENTURY    = 12'd100;

  localparam logic [8:0] SECS_PER_MIN  = 9'd60;
  localparam logic [8:0] MINS_PER_HOUR = 9'd60;
  localparam logic [8:0] HOURS_PER_DAY = 9'd24;
  localparam logic [4:0] DAYS_PER_WEEK = 5'd7;
  localparam logic [4:0] MONTHS        = 5'd12;
  localparam logic [4:0] ODD_MONTH_LEN = 5'd30;
  localparam logic [4:0] FEB_LEN       = 5'd28;
  localparam logic [4:0] FEB_LEAP_LEN  = 5'd29;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [3:0]  weekday;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } time_t;

  // Two BCD nibbles to binary; nibbles above nine are taken at face value.
  function automatic logic [7:0] bcd_decode(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'd0, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
  endfunction

  // Binary to BCD byte, tens*16 + units, low eight bits kept.
  // v/10 as (v*205)>>11, exact for all 8-bit values.
  function automatic logic [7:0] bcd_encode(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  tens;
    logic [7:0]  units;
    prod  = {8'd0, v} * 16'd205;
    tens  = prod[15:11];
    units = v - 8'({3'd0, tens} * 8'd10);
    return {tens[3:0], units[3:0]};
  endfunction

  // Year modulo 100: y/100 as (y*1311)>>17, exact below 4096.
  function automatic logic [6:0] year_mod100(input logic [11:0] y);
    logic [22:0] prod;
    logic [5:0]  q;
    logic [11:0] r;
    prod = {11'd0, y} * 23'd1311;
    q    = prod[22:17];
    r    = y - 12'({6'd0, q} * 12'd100);
    return r[6:0];
  endfunction

endpackage

// ===== rtl/core/bcc_cmd_if.sv =====
interface bcc_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] in_year_bcd;
  logic [7:0] in_month_week;
  logic [7:0] in_day_bcd;
  logic [7:0] in_hour_bcd;
  logic [7:0] in_minute_bcd;
  logic [7:0] in_second_bcd;

  modport source (
    output valid, mode, in_year_bcd, in_month_week, in_day_bcd,
           in_hour_bcd, in_minute_bcd, in_second_bcd,
    input  ready
  );
  modport sink (
    input  valid, mode, in_year_bcd, in_month_week, in_day_bcd,
           in_hour_bcd, in_minute_bcd, in_second_bcd,
    output ready
  );
endinterface

// ===== rtl/core/bcc_rsp_if.sv =====
interface bcc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_year_bcd;
  logic [7:0] out_month_week;
  logic [7:0] out_day_bcd;
  logic [7:0] out_hour_bcd;
  logic [7:0] out_minute_bcd;
  logic [7:0] out_second_bcd;

  modport source (
    output valid, out_year_bcd, out_month_week, out_day_bcd,
           out_hour_bcd, out_minute_bcd, out_second_bcd,
    input  ready
  );
  modport sink (
    input  valid, out_year_bcd, out_month_week, out_day_bcd,
           out_hour_bcd, out_minute_bcd, out_second_bcd,
    output ready
  );
endinterface

// ===== rtl/core/bcc_advance.sv =====
module bcc_advance
  import bcc_pkg::*;
(
  input  time_t cur,
  output time_t nxt,
  output logic  day_step
);

  logic [8:0] sec1, min1, hour1;
  logic [8:0] day1;
  logic [4:0] month1, wd1, limit;
  logic [3:0] month_idx;

  always_comb begin
    sec1      = {1'b0, cur.second} + 9'd1;
    min1      = {1'b0, cur.minute} + 9'd1;
    hour1     = {1'b0, cur.hour} + 9'd1;
    day1      = {1'b0, cur.day} + 9'd1;
    month1    = {1'b0, cur.month} + 5'd1;
    wd1       = {1'b0, cur.weekday} + 5'd1;
    month_idx = cur.month - 4'd1;
    nxt       = cur;
    day_step  = 1'b0;

    // month length uses the month and year before this step
    if (cur.month >= 4'd1 && {1'b0, cur.month} <= MONTHS) begin
      limit = MONTH_LEN[month_idx];
      if (limit == FEB_LEN && cur.year[1:0] == 2'd0) begin
        limit = FEB_LEAP_LEN;
      end
    end else begin
      limit = ODD_MONTH_LEN;
    end

    if (sec1 < SECS_PER_MIN) begin
      nxt.second = sec1[7:0];
    end else begin
      nxt.second = '0;
      if (min1 < MINS_PER_HOUR) begin
        nxt.minute = min1[7:0];
      end else begin
        nxt.minute = '0;
        if (hour1 < HOURS_PER_DAY) begin
          nxt.hour = hour1[7:0];
        end else begin
          nxt.hour = '0;
          day_step = 1'b1;
          // weekday+1 is at most 16, so two folds cover mod 7
          if (wd1 >= (DAYS_PER_WEEK << 1)) begin
            nxt.weekday = 4'(wd1 - (DAYS_PER_WEEK << 1));
          end else if (wd1 >= DAYS_PER_WEEK) begin
            nxt.weekday = 4'(wd1 - DAYS_PER_WEEK);
          end else begin
            nxt.weekday = wd1[3:0];
          end
          if (day1 <= {4'd0, limit}) begin
            nxt.day = day1[7:0];
          end else begin
            nxt.day = 8'd1;
            if (month1 <= MONTHS) begin
              nxt.month = month1[3:0];
            end else begin
              nxt.month = 4'd1;
              nxt.year  = cur.year + 12'd1;
            end
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/bcd_calendar_clock.sv =====
// Calendar clock with a fractional prescaler. Send items on cmd: a tick item
// (mode 0) adds tick_increment to an 11-bit prescaler and, once it reaches
// tick_period, subtracts the period and advances the time by one second with
// carry through minutes, hours, day and weekday, month and year. A set item
// (mode 1) loads the time from five BCD bytes and a byte of binary month and
// weekday nibbles; years decoding below 80 are taken as 20xx. A get item
// (mode 2) returns one item on rsp with the time in the same layout; tick,
// set and mode 3 return nothing. Rate is one item per clock while cmd.ready
// is high: an accepted item is held in the command register, where the
// prescaler add/compare and the second carry chain update the time, and a get
// result is then registered in the result register. cmd.ready drops only
// while a get waits in the command register and the result register still
// holds an item not taken. Write tick_increment (index 0) and tick_period
// (index 1) only while no item is in flight; other indexes are ignored.
module bcd_calendar_clock
  import bcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  bcc_cmd_if.sink              cmd,
  bcc_rsp_if.source            rsp
);

  // configuration
  logic [CFG_W-1:0] tick_increment;
  logic [CFG_W-1:0] tick_period;

  // command register
  logic       s_valid;
  logic [1:0] s_mode;
  logic [7:0] s_year, s_month_week, s_day, s_hour, s_minute, s_second;

  // clock state
  time_t       cur;
  logic [10:0] prescale_acc;

  // result register
  logic out_valid;

  logic        advance;
  logic        is_get;
  logic [11:0] sum;
  logic        sec_step;
  logic [10:0] prescale_acc_next;
  time_t       tick_time;
  time_t       set_time;
  logic        day_step;
  logic [11:0] set_year_raw;

  bcc_advance u_advance (
    .cur      (cur),
    .nxt      (tick_time),
    .day_step (day_step)
  );

  // the command register drains unless a get would overwrite a waiting result
  assign is_get    = (s_mode == MODE_GET);
  assign advance   = s_valid && !(is_get && out_valid && !rsp.ready);
  assign cmd.ready = !s_valid || advance;
  assign rsp.valid = out_valid;

  // prescaler: at most one second per tick
  always_comb begin
    sum      = {1'b0, prescale_acc} + {2'd0, tick_increment};
    sec_step = (sum >= {2'd0, tick_period});
    if (sec_step) begin
      prescale_acc_next = 11'(sum - {2'd0, tick_period});
    end else begin
      prescale_acc_next = sum[10:0];
    end
  end

  // time loaded by a set item
  always_comb begin
    set_year_raw     = YEAR_BASE + {4'd0, bcd_decode(s_year)};
    set_time.year    = (set_year_raw < YEAR_PIVOT) ? set_year_raw + CENTURY : set_year_raw;
    set_time.month   = s_month_week[7:4];
    set_time.weekday = s_month_week[3:0];
    set_time.day     = bcd_decode(s_day);
    set_time.hour    = bcd_decode(s_hour);
    set_time.minute  = bcd_decode(s_minute);
    set_time.second  = bcd_decode(s_second);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_increment <= TICK_INCREMENT_RESET;
      tick_period    <= TICK_PERIOD_RESET;
      s_valid        <= 1'b0;
      out_valid      <= 1'b0;
      prescale_acc   <= '0;
      cur.year       <= YEAR_RESET;
      cur.month      <= 4'd1;
      cur.weekday    <= '0;
      cur.day        <= 8'd1;
      cur.hour       <= '0;
      cur.minute     <= '0;
      cur.second     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TICK_INCREMENT: tick_increment <= cfg_data;
          CFG_TICK_PERIOD:    tick_period    <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.ready) begin
        s_valid <= cmd.valid;
      end

      if (advance) begin
        case (s_mode)
          MODE_TICK: begin
            prescale_acc <= prescale_acc_next;
            if (sec_step) begin
              cur <= tick_time;
            end
          end
          MODE_SET: begin
            cur <= set_time;
          end
          default: ;
        endcase
      end

      if (advance && is_get) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s_mode       <= cmd.mode;
      s_year       <= cmd.in_year_bcd;
      s_month_week <= cmd.in_month_week;
      s_day        <= cmd.in_day_bcd;
      s_hour       <= cmd.in_hour_bcd;
      s_minute     <= cmd.in_minute_bcd;
      s_second     <= cmd.in_second_bcd;
    end
    if (advance && is_get) begin
      rsp.out_year_bcd   <= bcd_encode({1'b0, year_mod100(cur.year)});
      rsp.out_month_week <= {cur.month, cur.weekday};
      rsp.out_day_bcd    <= bcd_encode(cur.day);
      rsp.out_hour_bcd   <= bcd_encode(cur.hour);
      rsp.out_minute_bcd <= bcd_encode(cur.minute);
      rsp.out_second_bcd <= bcd_encode(cur.second);
    end
  end

  // a result only ever follows a get leaving the command register
  a_rsp_from_get: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && is_get))
    else $error("result raised without a get item");

  // a tick below the period leaves the time alone
  a_tick_no_step: assert property (@(posedge clk) disable iff (rst)
    (advance && s_mode == MODE_TICK && !sec_step) |=> $stable(cur))
    else $error("time changed on a tick without a second step");

  // the weekday is folded into range on every day change made by a tick
  a_weekday_fold: assert property (@(posedge clk) disable iff (rst)
    (advance && s_mode == MODE_TICK && sec_step && day_step) |=> (cur.weekday < 4'd7))
    else $error("weekday out of range after day step");

endmodule
